// ===== hw/rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Command codes, status codes and cell control type for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque chain; shifts toward either neighbor or
// takes the pushed word when it is the next rear slot.
// ----------------------------------------------------------------------------
module cdq_cell #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 4,
  parameter int INDEX     = 0
) (
  input  logic                  clk,
  input  cdq_pkg::cell_ctl_t    ctl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [WORD_BITS-1:0]  word_i,
  input  logic [WORD_BITS-1:0]  prev_i,
  input  logic [WORD_BITS-1:0]  next_i,
  output logic [WORD_BITS-1:0]  data_o,
  output logic [WORD_BITS-1:0]  tap_o
);

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;
  logic                 is_tail;
  logic                 is_rear;

  assign is_tail = (count_i == CNT_W'(INDEX));
  assign is_rear = (count_i == CNT_W'(INDEX + 1));

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.push_front) begin
      data_nxt = prev_i;
    end else if (ctl_i.push_rear && is_tail) begin
      data_nxt = word_i;
    end else if (ctl_i.pop_front) begin
      data_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign tap_o  = is_rear ? data_r : '0;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH words held in a chain of shifting cells.
//
//   channel | ports                      | payload
//   in      | in_tvalid/in_tready/tdata  | command, push_word
//   out     | out_tvalid/out_tready/tdata| status, popped_word, fill_count
//
// One command per cycle; its result appears in the output register on the
// next cycle. A front push or pop shifts every cell one place; a rear push
// writes the cell at the fill count. Reset clears the fill count and the
// output valid flag; cell contents stay undefined until written. A held
// result stalls input only while out_tready is low.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int DEPTH     = 8,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] command, [33:2] push_word, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [33:2] popped_word,
                                  // [37:34] fill_count, rest zero
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic [39:0]          out_data_r;
  logic [39:0]          out_data_nxt;
  logic                 fire;
  logic                 full;
  logic                 empty;
  cdq_pkg::cmd_t        cmd;
  cdq_pkg::status_t     status;
  cdq_pkg::cell_ctl_t   ctl;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] popped;
  logic [WORD_BITS-1:0] rear_word;
  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [WORD_BITS-1:0] cell_tap  [DEPTH];

  assign cmd       = cdq_pkg::cmd_t'(in_tdata[1:0]);
  assign word      = WORD_BITS'(in_tdata[33:2]);
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tap[i];
    end
  end

  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    status    = cdq_pkg::ST_DONE;
    popped    = '0;
    unique case (cmd) inside
      cdq_pkg::CMD_PUSH_REAR, cdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status = cdq_pkg::ST_FULL;
        end else begin
          ctl.push_rear  = fire && (cmd == cdq_pkg::CMD_PUSH_REAR);
          ctl.push_front = fire && (cmd == cdq_pkg::CMD_PUSH_FRONT);
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          ctl.pop_front = fire;
          popped        = cell_data[0];
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
        if (empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          popped    = rear_word;
          count_nxt = count_r - CNT_W'(1);
        end
      end
    endcase
    out_data_nxt = {2'b00, 4'(count_nxt), 32'(popped), status};
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] prev_w;
    logic [WORD_BITS-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = word;
    end else begin : g_mid
      assign prev_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_data[g];
    end else begin : g_inner
      assign next_w = cell_data[g+1];
    end
    cdq_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (g)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .count_i (count_r),
      .word_i  (word),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (cell_data[g]),
      .tap_o   (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    fire && full && (cmd == cdq_pkg::CMD_PUSH_REAR || cmd == cdq_pkg::CMD_PUSH_FRONT)
    |=> out_valid_r && out_data_r[1:0] == cdq_pkg::ST_FULL && $stable(count_r))
    else $error("push to full queue not rejected");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fire && empty && (cmd == cdq_pkg::CMD_POP_FRONT || cmd == cdq_pkg::CMD_POP_REAR)
    |=> out_valid_r && out_data_r[1:0] == cdq_pkg::ST_EMPTY && count_r == '0)
    else $error("pop from empty queue not rejected");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !empty && (cmd == cdq_pkg::CMD_POP_FRONT || cmd == cdq_pkg::CMD_POP_REAR)
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not drop fill count");

endmodule

// ===== tb/circular_deque_test.sv =====
// ----------------------------------------------------------------------------
// circular_deque_test
// Self-checking bench for the shifting-cell deque. A scoreboard class keeps its
// own copy of the ring, the front and rear slots and the fill count. It works
// out the status, popped word and fill count for every command transfer and
// compares each result transfer against them in order. A directed pass covers
// empty and full rejections, emptying pushes and pops, front wrap and extreme
// words. Random bursts drift between push-heavy and pop-heavy so the queue
// sweeps between empty and full. Sender gaps and receiver stalls change by
// phase.
// ----------------------------------------------------------------------------
typedef struct packed {
  cdq_pkg::status_t status;
  logic [31:0]      popped_word;
  logic [3:0]       fill_count;
} deque_result_t;

class deque_scoreboard #(int DEPTH = 8, int WORD_BITS = 32);
  logic [31:0]   ring [DEPTH];
  int unsigned   front_slot;
  int unsigned   rear_slot;
  int unsigned   fill;
  deque_result_t pending_results [$];
  int            errors;

  function new();
    front_slot = 0;
    rear_slot  = 0;
    fill       = 0;
    errors     = 0;
    foreach (ring[i]) ring[i] = '0;
  endfunction

  function int unsigned step_up(int unsigned slot);
    return (slot + 1 >= DEPTH) ? 0 : slot + 1;
  endfunction

  function int unsigned step_down(int unsigned slot);
    return (slot == 0) ? DEPTH - 1 : slot - 1;
  endfunction

  function void note_command(cdq_pkg::cmd_t cmd, logic [31:0] push_word);
    deque_result_t r;
    logic [63:0]   word_mask;
    logic [31:0]   word;
    word_mask     = ~64'd0 >> (64 - WORD_BITS);
    word          = 32'({32'd0, push_word} & word_mask);
    r.status      = cdq_pkg::ST_DONE;
    r.popped_word = '0;
    if (cmd == cdq_pkg::CMD_PUSH_REAR || cmd == cdq_pkg::CMD_PUSH_FRONT) begin
      if (fill >= DEPTH) begin
        r.status = cdq_pkg::ST_FULL;
      end else begin
        if (fill == 0) begin
          front_slot = 0;
          rear_slot  = 0;
          ring[0]    = word;
        end else if (cmd == cdq_pkg::CMD_PUSH_REAR) begin
          rear_slot       = step_up(rear_slot);
          ring[rear_slot] = word;
        end else begin
          front_slot       = step_down(front_slot);
          ring[front_slot] = word;
        end
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = cdq_pkg::ST_EMPTY;
      end else begin
        if (cmd == cdq_pkg::CMD_POP_FRONT) begin
          r.popped_word = ring[front_slot];
          front_slot    = step_up(front_slot);
        end else begin
          r.popped_word = ring[rear_slot];
          rear_slot     = step_down(rear_slot);
        end
        fill--;
        if (fill == 0) begin
          front_slot = 0;
          rear_slot  = 0;
        end
      end
    end
    r.fill_count = 4'(fill);
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [39:0] data);
    deque_result_t e;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing expected: %h", data);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (data[1:0] !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, data[1:0]);
      errors++;
    end
    if (data[33:2] !== e.popped_word) begin
      $error("popped_word: expected %h, actual %h", e.popped_word, data[33:2]);
      errors++;
    end
    if (data[37:34] !== e.fill_count) begin
      $error("fill_count: expected %0d, actual %0d", e.fill_count, data[37:34]);
      errors++;
    end
    if (data[39:38] !== 2'b00) begin
      $error("padding: expected 0, actual %b", data[39:38]);
      errors++;
    end
  endfunction
endclass

module circular_deque_test;
  localparam int DEPTH        = 8;
  localparam int WORD_BITS    = 32;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1625;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  deque_scoreboard #(DEPTH, WORD_BITS) sb;

  circular_deque #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("circular_deque regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called right after a rising edge; returns right after the transfer edge.
  task automatic send_command(cdq_pkg::cmd_t cmd, logic [31:0] push_word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'd0, push_word, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, push_word);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned   push_bias;
    int unsigned   burst_left;
    cdq_pkg::cmd_t cmd;
    burst_left = 0;
    push_bias  = 50;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 40);
        push_bias  = $urandom_range(0, 100);
      end
      burst_left--;
      if ($urandom_range(99) < push_bias) begin
        cmd = $urandom_range(1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
      end else begin
        cmd = $urandom_range(1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_REAR;
      end
      send_command(cmd, pick_word());
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // empty rejections, single-word fill and drain from both ends
    send_command(cdq_pkg::CMD_POP_FRONT,  32'h1234_5678);
    send_command(cdq_pkg::CMD_POP_REAR,   32'hFFFF_FFFF);
    send_command(cdq_pkg::CMD_PUSH_REAR,  32'h7FFF_FFFF);
    send_command(cdq_pkg::CMD_POP_REAR,   32'h0000_0000);
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(cdq_pkg::CMD_POP_FRONT,  32'h0000_0000);
    // fill to full with front wrap, then full rejections
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    send_command(cdq_pkg::CMD_PUSH_REAR,  32'h8000_0000);
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_command(cdq_pkg::CMD_PUSH_REAR,  32'hA5A5_A5A5);
    send_command(cdq_pkg::CMD_PUSH_REAR,  32'h5A5A_5A5A);
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
    send_command(cdq_pkg::CMD_PUSH_REAR,  32'hFFFF_FFFE);
    send_command(cdq_pkg::CMD_PUSH_REAR,  32'hDEAD_0000);
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_BEEF);
    // drain from both ends through the wrapped slots
    repeat (4) send_command(cdq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    repeat (4) send_command(cdq_pkg::CMD_POP_REAR,  32'h0000_0000);
    send_command(cdq_pkg::CMD_POP_FRONT, 32'h0000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      run_random(RANDOM_ITEMS / 4);
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("circular_deque regression: pass");
    end else begin
      $display("circular_deque regression: fail");
    end
    $finish;
  end
endmodule
